/* design/assert_macros.svh */
// assertion macros used by the matcher core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle
`define ORM_ASSERT_IMP(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// condition holds in the next cycle
`define ORM_ASSERT_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

/* design/orm_pkg.sv */
// types and constants of the online ranking matcher
package orm_pkg;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_RANK     = 2'd1;
   localparam logic [1:0] KIND_FALLBACK = 2'd2;
   localparam logic [1:0] KIND_ARRIVAL  = 2'd3;

   localparam logic [6:0] ACTIVE_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  position;
      logic [5:0]  vertex;
      logic [63:0] neighbor_mask;
   } req_type;

   typedef struct packed {
      logic       matched;
      logic [5:0] matched_vertex;
      logic       by_rank;
      logic [6:0] rank1_count;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic       found;
      logic [5:0] best;
      logic [5:0] rank;
   } token_type;

   typedef struct packed {
      logic       clear;
      logic       set;
      logic [5:0] set_vertex;
      logic       load;
      logic [5:0] load_vertex;
      logic [5:0] load_rank;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FALLBACK
   } state_type;

endpackage

/* design/online_ranking_matcher_core.sv */
// top level of the online ranking matcher
//
//   channel  ports                       handshake
//   request  start, busy, req_word       taken when start and not busy
//   result   rsp_strobe, rsp_word        one-cycle strobe, no back pressure
//   csr      csr_valid, csr_ready, csr_data  taken when valid and ready
//
// load and start words leave the block idle
// an arrival walks a token down the row of VERTICES cells,
// then the fallback walk reads one fallback entry per cycle
// the result strobe is high in the first cycle with busy low
// synchronous reset clears used flags, pointer and count, and sets the active count to 64
`include "assert_macros.svh"

module online_ranking_matcher_core #(
   parameter int VERTICES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  orm_pkg::req_type req_word,
   output logic             rsp_strobe,
   output orm_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_data
);
   import orm_pkg::*;

   localparam int IDX_W = (VERTICES > 1) ? $clog2(VERTICES) : 1;

   state_type    state_ff;
   state_type    state_in;
   logic [6:0]   active_ff;
   logic [6:0]   active_n;
   logic [6:0]   ptr_ff;
   logic [6:0]   ptr_in;
   logic [6:0]   ptr_nx;
   logic [6:0]   rank1_ff;
   logic [6:0]   rank1_in;
   logic [6:0]   rank1_inc;
   logic [63:0]  mask_ff;
   logic [63:0]  mask_in;
   token_type    launch_ff;
   token_type    launch_in;
   rsp_type      rsp_ff;
   rsp_type      rsp_in;
   logic         rsp_strobe_ff;
   logic         rsp_strobe_in;
   cell_ctl_type ctl;
   logic         accept;
   logic         in_range;
   logic         fb_we;
   logic [5:0]   fb_mem [VERTICES];
   logic [5:0]   fb_rd_ff;
   logic         fb_used;
   logic [VERTICES-1:0] used_vec;
   logic [VERTICES-1:0] tok_valid;
   token_type    tok_chain [VERTICES+1];
   token_type    last_tok;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign active_n  = (active_ff > 7'(VERTICES)) ? 7'(VERTICES) : active_ff;
   assign in_range  = ({1'b0, req_word.position} < 7'(VERTICES)) &&
                      ({1'b0, req_word.vertex} < 7'(VERTICES));
   assign ptr_nx    = ptr_ff + 7'd1;
   assign rank1_inc = (rank1_ff == 7'h7F) ? rank1_ff : rank1_ff + 7'd1;
   assign fb_used   = used_vec[fb_rd_ff[IDX_W-1:0]];

   // row of vertex cells
   assign tok_chain[0] = launch_ff;
   for (genvar g = 0; g < VERTICES; g++) begin : g_cell
      orm_cell #(.INDEX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .active_n (active_n),
         .mask_bit (mask_ff[g]),
         .tok_in   (tok_chain[g]),
         .tok_out  (tok_chain[g+1]),
         .used     (used_vec[g])
      );
      assign tok_valid[g] = tok_chain[g+1].valid;
   end
   assign last_tok = tok_chain[VERTICES];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.kind == KIND_ARRIVAL) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_tok.valid) begin
               if (last_tok.found || ptr_ff >= active_n) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FALLBACK;
               end
            end
         end
         ST_FALLBACK: begin
            if (!fb_used || ptr_nx >= active_n) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      ctl           = '0;
      launch_in     = '0;
      mask_in       = mask_ff;
      ptr_in        = ptr_ff;
      rank1_in      = rank1_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      fb_we         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.kind)
                  KIND_START: begin
                     ctl.clear = 1'b1;
                     ptr_in    = '0;
                     rank1_in  = '0;
                  end
                  KIND_RANK: begin
                     ctl.load        = in_range;
                     ctl.load_vertex = req_word.vertex;
                     ctl.load_rank   = req_word.position;
                  end
                  KIND_FALLBACK: begin
                     fb_we = in_range;
                  end
                  KIND_ARRIVAL: begin
                     launch_in.valid = 1'b1;
                     mask_in         = req_word.neighbor_mask;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (last_tok.valid) begin
               if (last_tok.found) begin
                  ctl.set        = 1'b1;
                  ctl.set_vertex = last_tok.best;
                  rank1_in       = rank1_inc;
                  rsp_strobe_in  = 1'b1;
                  rsp_in         = '{1'b1, last_tok.best, 1'b1, rank1_inc};
               end else if (ptr_ff >= active_n) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{1'b0, 6'd0, 1'b0, rank1_ff};
               end
            end
         end
         ST_FALLBACK: begin
            ptr_in = ptr_nx;
            if (fb_used) begin
               if (ptr_nx >= active_n) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{1'b0, 6'd0, 1'b0, rank1_ff};
               end
            end else begin
               ctl.set        = 1'b1;
               ctl.set_vertex = fb_rd_ff;
               rsp_strobe_in  = 1'b1;
               rsp_in         = '{1'b1, fb_rd_ff, 1'b0, rank1_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= ACTIVE_RESET;
         ptr_ff        <= '0;
         rank1_ff      <= '0;
         launch_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         rank1_ff      <= rank1_in;
         launch_ff     <= launch_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            active_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   // fallback order table, read at the next pointer value
   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_mem[req_word.position[IDX_W-1:0]] <= req_word.vertex;
      end
      fb_rd_ff <= fb_mem[ptr_in[IDX_W-1:0]];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   `ORM_ASSERT_IMP(a_token_single, 1'b1, $onehot0(tok_valid))
   `ORM_ASSERT_NEXT(a_rsp_after_busy, rsp_strobe_in, rsp_strobe && !busy)
   `ORM_ASSERT_IMP(a_rank_implies_match, rsp_strobe && rsp_word.by_rank, rsp_word.matched)
   `ORM_ASSERT_IMP(a_unmatched_zero,
      rsp_strobe && !rsp_word.matched, rsp_word.matched_vertex == 6'd0)

endmodule

/* design/orm_cell.sv */
// one offline vertex: used flag, rank and one step of the best-neighbor scan
module orm_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  orm_pkg::cell_ctl_type ctl,
   input  logic [6:0]            active_n,
   input  logic                  mask_bit,
   input  orm_pkg::token_type    tok_in,
   output orm_pkg::token_type    tok_out,
   output logic                  used
);
   import orm_pkg::*;

   logic       used_ff;
   logic       used_in;
   logic [5:0] rank_ff;
   token_type  tok_ff;
   token_type  tok_in_next;
   logic       hit;
   logic       take;

   always_comb begin
      used_in = used_ff;
      if (ctl.clear) begin
         used_in = 1'b0;
      end else if (ctl.set && ctl.set_vertex == 6'(INDEX)) begin
         used_in = 1'b1;
      end
   end

   assign hit  = tok_in.valid && mask_bit && !used_ff && (7'(INDEX) < active_n);
   assign take = hit && (!tok_in.found || rank_ff < tok_in.rank);

   always_comb begin
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.best  = 6'(INDEX);
         tok_in_next.rank  = rank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         tok_ff  <= '0;
      end else begin
         used_ff <= used_in;
         tok_ff  <= tok_in_next;
      end
   end

   // rank table entry, undefined until loaded
   always_ff @(posedge clock) begin
      if (ctl.load && ctl.load_vertex == 6'(INDEX)) begin
         rank_ff <= ctl.load_rank;
      end
   end

   assign tok_out = tok_ff;
   assign used    = used_ff;

endmodule

/* sim/match_result_checker.sv */
// checker for the online ranking matcher: predicts each match and compares it with the block
module match_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  orm_pkg::req_type req_word,
   input  logic             rsp_strobe,
   input  orm_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [6:0]       csr_data,
   output int               mismatch_count,
   output int               outstanding
);
   import orm_pkg::*;

   logic [63:0] used_flags;
   logic [5:0]  rank_of [64];
   logic [5:0]  fallback_at [64];
   int          fallback_ptr;
   int          rank_hits;
   logic [6:0]  active_vertices;
   rsp_type     pending_matches [$];
   rsp_type     want;

   function automatic rsp_type match_arrival(logic [63:0] mask);
      int         n;
      logic [63:0] free_nb;
      logic       found;
      int         best;
      logic [5:0] best_rank;
      rsp_type    r;
      n = (active_vertices > 7'd64) ? 64 : int'(active_vertices);
      free_nb = mask & ~used_flags;
      if (n < 64) free_nb = free_nb & ((64'd1 << n) - 64'd1);
      found = 1'b0;
      best = 0;
      best_rank = '0;
      for (int v = 0; v < n; v++) begin
         if (free_nb[v] && (!found || rank_of[v] < best_rank)) begin
            found = 1'b1;
            best = v;
            best_rank = rank_of[v];
         end
      end
      r = '0;
      if (found) begin
         used_flags[best] = 1'b1;
         if (rank_hits < 127) rank_hits++;
         r.matched = 1'b1;
         r.by_rank = 1'b1;
         r.matched_vertex = 6'(best);
      end else begin
         while (fallback_ptr < n && used_flags[fallback_at[fallback_ptr]]) fallback_ptr++;
         if (fallback_ptr < n) begin
            r.matched = 1'b1;
            r.matched_vertex = fallback_at[fallback_ptr];
            used_flags[fallback_at[fallback_ptr]] = 1'b1;
            fallback_ptr++;
         end
      end
      r.rank1_count = 7'(rank_hits);
      return r;
   endfunction

   function automatic void check_field(string field, int expected_val, int actual_val);
      if (expected_val != actual_val) begin
         $display("%0t: %s expected %0d got %0d", $time, field, expected_val, actual_val);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         used_flags = '0;
         fallback_ptr = 0;
         rank_hits = 0;
         active_vertices = ACTIVE_RESET;
         mismatch_count = 0;
         pending_matches.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_matches.size() == 0) begin
               $display("%0t: result expected none got %0d/%0d/%0d/%0d", $time,
                        rsp_word.matched, rsp_word.matched_vertex, rsp_word.by_rank,
                        rsp_word.rank1_count);
               mismatch_count++;
            end else begin
               want = pending_matches.pop_front();
               check_field("matched", int'(want.matched), int'(rsp_word.matched));
               check_field("matched_vertex", int'(want.matched_vertex),
                           int'(rsp_word.matched_vertex));
               check_field("by_rank", int'(want.by_rank), int'(rsp_word.by_rank));
               check_field("rank1_count", int'(want.rank1_count),
                           int'(rsp_word.rank1_count));
            end
         end
         if (csr_valid && csr_ready) active_vertices = csr_data;
         if (start && !busy) begin
            case (req_word.kind)
               KIND_START: begin
                  used_flags = '0;
                  fallback_ptr = 0;
                  rank_hits = 0;
               end
               KIND_RANK: rank_of[req_word.vertex] = req_word.position;
               KIND_FALLBACK: fallback_at[req_word.position] = req_word.vertex;
               default: pending_matches = {pending_matches,
                                           match_arrival(req_word.neighbor_mask)};
            endcase
         end
      end
      outstanding = pending_matches.size();
   end

endmodule

/* sim/online_ranking_matcher_core_tb.sv */
// testbench top for the online ranking matcher: stimulus, clock, reset and verdict
module online_ranking_matcher_core_tb;
   import orm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 200;
   localparam int ITEM_TARGET = 800;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_word = '0;
   logic       rsp_strobe;
   rsp_type    rsp_word;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   int mismatch_count;
   int outstanding;
   int cycles = 0;
   int idle_pct = 0;
   int items_sent = 0;
   int order [64];

   online_ranking_matcher_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   match_result_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] kind, logic [5:0] pos, logic [5:0] vtx,
                            logic [63:0] mask);
      req_type w;
      w.kind = kind;
      w.position = pos;
      w.vertex = vtx;
      w.neighbor_mask = mask;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(logic [6:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] random_mask();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         4: return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int run;
      int arrivals;
      int nn;
      int j;
      int tmp;
      int pick;
      logic [6:0] act;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // small table with ties, out-of-range fallback entries and a duplicate
      write_active(7'd4);
      send_word(KIND_RANK, 6'd3, 6'd0, '0);
      send_word(KIND_RANK, 6'd0, 6'd1, '0);
      send_word(KIND_RANK, 6'd0, 6'd2, '0);
      send_word(KIND_RANK, 6'd63, 6'd3, '0);
      send_word(KIND_RANK, 6'd63, 6'd63, '1);
      send_word(KIND_FALLBACK, 6'd0, 6'd1, '0);
      send_word(KIND_FALLBACK, 6'd1, 6'd63, '0);
      send_word(KIND_FALLBACK, 6'd2, 6'd0, '0);
      send_word(KIND_FALLBACK, 6'd3, 6'd1, '0);
      send_word(KIND_FALLBACK, 6'd63, 6'd63, '0);
      send_word(KIND_START, 6'd0, 6'd0, '0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '1);
      send_word(KIND_ARRIVAL, 6'd63, 6'd63, 64'h6);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, 64'h2);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, 64'hFFFF_FFFF_FFFF_FFF0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, 64'h8);
      // no vertex in use
      write_active(7'd0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '1);
      // shrink the active range under a moved fallback pointer
      write_active(7'd4);
      send_word(KIND_START, 6'd0, 6'd0, '0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '0);
      write_active(7'd2);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, '0);
      send_word(KIND_ARRIVAL, 6'd0, 6'd0, 64'h1);

      // fill both tables before any wide run
      write_active(7'd64);
      for (int v = 0; v < 64; v++) send_word(KIND_RANK, 6'($urandom_range(63)), 6'(v),
                                            random_mask());
      for (int i = 0; i < 64; i++) order[i] = i;
      for (int i = 63; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int p = 0; p < 64; p++) send_word(KIND_FALLBACK, 6'(p), 6'(order[p]), random_mask());

      run = 0;
      while (items_sent < ITEM_TARGET) begin
         case (run % 3)
            0: idle_pct = 0;
            1: idle_pct = 66;
            default: idle_pct = 10;
         endcase
         case ($urandom_range(5))
            0: act = 7'd1;
            1: act = 7'd64;
            2: act = 7'd127;
            3: act = 7'($urandom_range(2, 8));
            default: act = 7'($urandom_range(1, 127));
         endcase
         write_active(act);
         send_word(KIND_START, 6'($urandom_range(63)), 6'($urandom_range(63)), random_mask());
         nn = (act > 7'd64) ? 64 : int'(act);
         arrivals = $urandom_range(1, nn + 4);
         for (int k = 0; k < arrivals; k++) begin
            pick = $urandom_range(99);
            if (pick < 6)
               send_word(KIND_RANK, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         random_mask());
            else if (pick < 10)
               send_word(KIND_FALLBACK, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         random_mask());
            else if (pick < 12)
               send_word(KIND_START, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         random_mask());
            else
               send_word(KIND_ARRIVAL, 6'($urandom_range(63)), 6'($urandom_range(63)),
                         random_mask());
         end
         run++;
      end

      drain();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
